// File: hdl/assert_macros.svh
// Assertion helpers shared by the echo block RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/sme_pkg.sv
// Shared constants and types for the stereo multitap echo block.
// No dependencies; used by the tap accumulator and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

  // Fixed field widths of the configuration registers
  localparam int GAIN_BITS      = 15;
  localparam int GAIN_FRAC      = 15;
  localparam int SPACING_BITS   = 11;
  localparam int TAPS_BITS      = 3;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_GAIN    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_SPACING = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAPS_IN_USE = 2'd2;

  // Reset values of the registers
  localparam logic [GAIN_BITS-1:0]    GAIN_RESET    = 15'd9830;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 11'd2000;
  localparam logic [TAPS_BITS-1:0]    TAPS_RESET    = 3'd4;

  // Control that travels with the store read data into the accumulator
  typedef struct packed {
    logic clear;   // start of a new request: zero the sums
    logic vld;     // store read data is a tap
    logic keep;    // entry has been written; otherwise it reads as zero
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hdl/sme_sample_if.sv
// Input channel: one stereo sample pair per request, valid/ready handshake.
// Depends on nothing; width follows SAMPLE_BITS.
`timescale 1ns / 1ps
`default_nettype none

interface sme_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

`default_nettype wire

// File: hdl/sme_echo_if.sv
// Output channel: one stereo echo pair per request, valid/ready handshake.
// Depends on nothing; width follows SAMPLE_BITS.
`timescale 1ns / 1ps
`default_nettype none

interface sme_echo_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] echo_left;
  logic signed [SAMPLE_BITS-1:0] echo_right;

  modport source (output valid, output echo_left, output echo_right, input ready);
  modport sink   (input valid, input echo_left, input echo_right, output ready);
endinterface

`default_nettype wire

// File: hdl/sme_store.sv
// Single-port history store holding left and right samples side by side.
// No package dependencies; one access per cycle, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sme_store #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read at one address; the read data is registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hdl/sme_mac.sv
// Tap accumulator: gain multiply, per-channel sum, floor shift and saturation.
// Uses sme_pkg (gain format, mac_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module sme_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire sme_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [SAMPLE_BITS-1:0]      data_left,
  input  wire logic signed [SAMPLE_BITS-1:0]      data_right,
  input  wire logic        [sme_pkg::GAIN_BITS-1:0] gain,
  output logic                                    busy,
  output logic signed [SAMPLE_BITS-1:0]           res_left,
  output logic signed [SAMPLE_BITS-1:0]           res_right
);

  localparam int PROD_W = SAMPLE_BITS + sme_pkg::GAIN_BITS + 1;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int SH_W   = ACC_W - sme_pkg::GAIN_FRAC;

  logic signed [SAMPLE_BITS-1:0] op_left, op_right;
  logic signed [PROD_W-1:0]      prod_left, prod_right;
  logic                          prod_vld;
  logic signed [ACC_W-1:0]       acc_left, acc_right;
  logic signed [SH_W-1:0]        sh_left, sh_right;

  // Entries never written read as zero
  assign op_left  = ctl.keep ? data_left  : '0;
  assign op_right = ctl.keep ? data_right : '0;

  // Product stage
  always_ff @(posedge clk) begin
    prod_left  <= PROD_W'(op_left)  * PROD_W'($signed({1'b0, gain}));
    prod_right <= PROD_W'(op_right) * PROD_W'($signed({1'b0, gain}));
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.vld;
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_left  <= '0;
      acc_right <= '0;
    end else if (prod_vld) begin
      acc_left  <= acc_left  + ACC_W'(prod_left);
      acc_right <= acc_right + ACC_W'(prod_right);
    end
  end

  assign busy = prod_vld;

  // Floor shift back to sample scale, then clamp
  assign sh_left  = SH_W'(acc_left  >>> sme_pkg::GAIN_FRAC);
  assign sh_right = SH_W'(acc_right >>> sme_pkg::GAIN_FRAC);

  always_comb begin
    if (sh_left[SH_W-1:SAMPLE_BITS-1] != {(SH_W-SAMPLE_BITS+1){sh_left[SH_W-1]}}) begin
      res_left = sh_left[SH_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      res_left = sh_left[SAMPLE_BITS-1:0];
    end
    if (sh_right[SH_W-1:SAMPLE_BITS-1] != {(SH_W-SAMPLE_BITS+1){sh_right[SH_W-1]}}) begin
      res_right = sh_right[SH_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      res_right = sh_right[SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/stereo_multitap_echo_top.sv
// Stereo multitap echo: history store, tap sequencer and accumulator.
// Uses sme_pkg, sme_sample_if, sme_echo_if, sme_store, sme_mac, assert_macros.svh.
//
// Usage:
//   samples (sink) takes one left/right pair per request; echoes (source)
//   returns one wet echo pair per request, the sum of taps_in_use taps (at most
//   MAX_TAPS) at delays tap_spacing, 2*tap_spacing, ... each scaled by tap_gain.
//   cfg_we/cfg_index/cfg_data write tap_gain (0), tap_spacing (1) and
//   taps_in_use (2); other indexes are ignored. Write only while idle.
// Timing (single-port store: one write, then one tap read per cycle into a
//   two-stage multiply-accumulate):
//   the result register loads once the last tap has left the accumulator
//   pipeline; samples.ready returns the cycle after, so a new request is
//   accepted only after the previous one has reached the output register.
// Reset (rst, synchronous): registers return to gain 9830, spacing 2000,
//   four taps; the write pointer goes to zero; ready stays low. Entries not
//   yet written read as zero through a fill flag, so no clearing pass is needed.
// Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and its result is held back until the slot frees.
// STORE_DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stereo_multitap_echo_top #(
  parameter int STORE_DEPTH = 8192,
  parameter int MAX_TAPS    = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sme_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [sme_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  sme_sample_if.sink                                samples,
  sme_echo_if.source                                echoes
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int TW = $clog2(MAX_TAPS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  // Configuration registers
  logic [sme_pkg::GAIN_BITS-1:0]    tap_gain;
  logic [sme_pkg::SPACING_BITS-1:0] tap_spacing;
  logic [sme_pkg::TAPS_BITS-1:0]    taps_in_use;

  logic [1:0]    state;
  logic [AW-1:0] pos, pos_cur, rd_addr;
  logic          wrapped;
  logic [TW-1:0] taps_eff, tap_cnt, taps_lim;
  logic          accept, issue, s1_vld, s1_keep, mac_busy, out_load, out_valid;
  logic [AW-1:0] space_a;
  logic [AW-1:0] st_addr;
  logic [2*SAMPLE_BITS-1:0] st_wdata, st_rdata;
  sme_pkg::mac_ctl_t        mac_ctl;
  logic signed [SAMPLE_BITS-1:0] res_left, res_right;

  assign accept   = samples.valid && samples.ready;
  assign issue    = (state == S_READ);
  assign space_a  = AW'(tap_spacing);
  assign samples.ready = (state == S_IDLE) && !rst;

  // Tap count clamped to the hardware limit
  always_comb begin
    if ({1'b0, taps_in_use} > 4'(MAX_TAPS)) begin
      taps_lim = TW'(MAX_TAPS);
    end else begin
      taps_lim = TW'(taps_in_use);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_gain    <= sme_pkg::GAIN_RESET;
      tap_spacing <= sme_pkg::SPACING_RESET;
      taps_in_use <= sme_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sme_pkg::REG_TAP_GAIN:    tap_gain    <= cfg_data;
        sme_pkg::REG_TAP_SPACING: tap_spacing <= cfg_data[sme_pkg::SPACING_BITS-1:0];
        sme_pkg::REG_TAPS_IN_USE: taps_in_use <= cfg_data[sme_pkg::TAPS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Tap sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pos     <= '0;
      wrapped <= 1'b0;
      tap_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_cur  <= pos;
            rd_addr  <= pos - space_a;
            taps_eff <= taps_lim;
            tap_cnt  <= '0;
            pos      <= AW'(pos + 1'b1);
            if (pos == AW'(STORE_DEPTH - 1)) begin
              wrapped <= 1'b1;
            end
            state <= (taps_lim == '0) ? S_DRAIN : S_READ;
          end
        end
        S_READ: begin
          rd_addr <= rd_addr - space_a;
          tap_cnt <= TW'(tap_cnt + 1'b1);
          if (TW'(tap_cnt + 1'b1) == taps_eff) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Store access: write at accept, tap reads afterwards
  assign st_addr  = (state == S_IDLE) ? pos : rd_addr;
  assign st_wdata = {samples.sample_left, samples.sample_right};

  sme_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (2 * SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // Flags that travel with the read data
  always_ff @(posedge clk) begin
    s1_keep <= wrapped || (rd_addr <= pos_cur);
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
    end
  end

  assign mac_ctl.clear = accept;
  assign mac_ctl.vld   = s1_vld;
  assign mac_ctl.keep  = s1_keep;

  sme_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .ctl        (mac_ctl),
    .data_left  ($signed(st_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .data_right ($signed(st_rdata[SAMPLE_BITS-1:0])),
    .gain       (tap_gain),
    .busy       (mac_busy),
    .res_left   (res_left),
    .res_right  (res_right)
  );

  // Output register
  assign out_load = (state == S_DRAIN) && !s1_vld && !mac_busy
                    && (!out_valid || echoes.ready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      echoes.echo_left  <= res_left;
      echoes.echo_right <= res_right;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (echoes.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign echoes.valid = out_valid;

  // Checks
  `ASSERT_SAME(a_load_after_drain, clk, rst, out_load, !s1_vld && !mac_busy && !issue)
  `ASSERT_SAME(a_tap_bound, clk, rst, state == S_READ, tap_cnt < taps_eff)
  `ASSERT_NEXT(a_accept_busy, clk, rst, accept, !samples.ready)
  `ASSERT_SAME(a_no_clear_midsum, clk, rst, accept, !s1_vld && !mac_busy)

endmodule

`default_nettype wire
